### rtl/core/ebcpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Shared widths, operation codes and record types of the 8-bit execute core.
// ----------------------------------------------------------------------------
package ebcpu_pkg;

	localparam int FUNC_W = 6;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h80;
	localparam logic [BYTE_W-1:0] LOW_MASK  = 8'h01;

	typedef enum logic [FUNC_W-1:0] {
		OP_ADC     = 6'd0,
		OP_SBC     = 6'd1,
		OP_AND     = 6'd2,
		OP_CMP     = 6'd3,
		OP_CPX     = 6'd4,
		OP_CPY     = 6'd5,
		OP_INC_A   = 6'd6,
		OP_INC_MEM = 6'd7,
		OP_DEC_A   = 6'd8,
		OP_DEC_MEM = 6'd9,
		OP_INX     = 6'd10,
		OP_INY     = 6'd11,
		OP_DEX     = 6'd12,
		OP_DEY     = 6'd13,
		OP_LDA     = 6'd14,
		OP_LDX     = 6'd15,
		OP_LDY     = 6'd16,
		OP_TXA     = 6'd17,
		OP_TYA     = 6'd18,
		OP_ROL_A   = 6'd19,
		OP_ROL_MEM = 6'd20,
		OP_ROR_A   = 6'd21,
		OP_ROR_MEM = 6'd22,
		OP_STA     = 6'd23,
		OP_STX     = 6'd24,
		OP_STY     = 6'd25,
		OP_CLC     = 6'd26,
		OP_CLD     = 6'd27,
		OP_CLI     = 6'd28,
		OP_CLV     = 6'd29,
		OP_SEC     = 6'd30,
		OP_SED     = 6'd31,
		OP_SEI     = 6'd32,
		OP_BCC     = 6'd33,
		OP_BCS     = 6'd34,
		OP_BEQ     = 6'd35,
		OP_NOP     = 6'd36,
		OP_PHP     = 6'd37,
		OP_PLP     = 6'd38,
		OP_PHA     = 6'd39,
		OP_PHX     = 6'd40,
		OP_PHY     = 6'd41,
		OP_PLA     = 6'd42,
		OP_PLX     = 6'd43,
		OP_PLY     = 6'd44
	} func_t;

	// Architectural registers and flags.
	typedef struct packed {
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] xreg;
		logic [BYTE_W-1:0] yreg;
		logic              flag_c;
		logic              flag_z;
		logic              flag_v;
		logic              flag_n;
		logic              flag_d;
		logic              flag_i;
	} arch_state_t;

	// One result item.
	typedef struct packed {
		logic [BYTE_W-1:0] store_data;
		logic              store_valid;
		logic              branch_taken;
		logic [BYTE_W-1:0] acc_value;
		logic [BYTE_W-1:0] x_value;
		logic [BYTE_W-1:0] y_value;
		logic [BYTE_W-1:0] status_value;
	} result_t;

endpackage

### rtl/core/ebcpu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_in_if
// Command channel: operation code and fetched operand byte.
// ----------------------------------------------------------------------------
interface ebcpu_in_if import ebcpu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [BYTE_W-1:0] operand;

	modport source (output valid, func, operand, input ready);
	modport sink (input valid, func, operand, output ready);
endinterface

### rtl/core/ebcpu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_out_if
// Result channel: store byte, branch decision, registers and packed status.
// ----------------------------------------------------------------------------
interface ebcpu_out_if import ebcpu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] store_data;
	logic              store_valid;
	logic              branch_taken;
	logic [BYTE_W-1:0] acc_value;
	logic [BYTE_W-1:0] x_value;
	logic [BYTE_W-1:0] y_value;
	logic [BYTE_W-1:0] status_value;

	modport source (output valid, store_data, store_valid, branch_taken, acc_value,
		x_value, y_value, status_value, input ready);
	modport sink (input valid, store_data, store_valid, branch_taken, acc_value,
		x_value, y_value, status_value, output ready);
endinterface

### rtl/core/eight_bit_cpu_alu_register_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_register_execute_core
// Execute unit of an 8-bit CPU: ALU, A/X/Y registers and status flags.
//
// Channels: cmd carries one item per instruction (func, operand); res carries
// one result item per command item (store byte and mark, branch decision,
// A, X, Y and packed status N V 1 1 D I Z C after the instruction).
// Both use valid/ready; an item moves at a clock edge with both high.
// Flow: an item taken from cmd sits in the input register; its result is
// computed from the current registers and is loaded into the result register
// as soon as that register is free, which raises res.valid.
// Throughput: one item per cycle unless res stalls; registers and flags
// commit at the same edge as the result; the next item sees them immediately.
// Stall: while res is held off, the result register holds, the item in the
// input register waits, and cmd.ready drops once that register is full.
// Reset (arst_n low): both stages empty, A, X, Y and all flags cleared.
// Arithmetic is binary; D is stored and reported only.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_register_execute_core import ebcpu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ebcpu_in_if.sink   cmd,
	ebcpu_out_if.source res
);

	logic              s1_valid_q;
	logic [FUNC_W-1:0] func_s1;
	logic [BYTE_W-1:0] operand_s1;
	logic              out_valid_q;
	result_t           res_s2;

	logic              out_free;
	logic              advance;
	arch_state_t       cur_state;
	arch_state_t       nxt_state;
	result_t           alu_res;

	// Result register can take a new item when empty or being drained.
	assign out_free  = !out_valid_q || res.ready;
	assign advance   = s1_valid_q && out_free;
	assign cmd.ready = !s1_valid_q || out_free;

	// Input register: refill whenever it empties or advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1    <= cmd.func;
			operand_s1 <= cmd.operand;
		end
	end

	ebcpu_alu u_alu (
		.func    (func_s1),
		.operand (operand_s1),
		.cur     (cur_state),
		.nxt     (nxt_state),
		.res     (alu_res)
	);

	// Commit architectural state together with the result.
	ebcpu_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.nxt    (nxt_state),
		.cur    (cur_state)
	);

	// Result register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= alu_res;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.store_data   = res_s2.store_data;
	assign res.store_valid  = res_s2.store_valid;
	assign res.branch_taken = res_s2.branch_taken;
	assign res.acc_value    = res_s2.acc_value;
	assign res.x_value      = res_s2.x_value;
	assign res.y_value      = res_s2.y_value;
	assign res.status_value = res_s2.status_value;

	// Reported registers always match the committed state.
	a_regs_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_s2.acc_value == cur_state.acc
			&& res_s2.x_value == cur_state.xreg && res_s2.y_value == cur_state.yreg))
		else $error("result registers differ from committed state");

	// A stalled item in the input register is kept, not dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free) |=> s1_valid_q)
		else $error("input register lost a stalled item");

	// No store byte leaks out without its mark.
	a_store_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_s2.store_valid) |-> (res_s2.store_data == '0))
		else $error("store data nonzero without store mark");

	// Architectural state changes only when an item commits.
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cur_state))
		else $error("state changed without a committing item");

endmodule

### rtl/core/ebcpu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_alu
// Single-pass execute logic: next registers, flags and the result item.
// ----------------------------------------------------------------------------
module ebcpu_alu import ebcpu_pkg::*; (
	input  logic [FUNC_W-1:0] func,
	input  logic [BYTE_W-1:0] operand,
	input  arch_state_t       cur,
	output arch_state_t       nxt,
	output result_t           res
);

	func_t             op;
	logic [BYTE_W-1:0] add_m;
	logic [BYTE_W:0]   sum;
	logic [BYTE_W-1:0] cmp_reg;
	logic [BYTE_W:0]   diff;
	logic [BYTE_W-1:0] rot_src;
	logic [BYTE_W-1:0] rol_r;
	logic [BYTE_W-1:0] ror_r;
	logic [BYTE_W-1:0] zn_val;
	logic              zn_upd;
	logic [BYTE_W-1:0] sd;
	logic              sv;
	logic              br;

	assign op = func_t'(func);

	// Adder: SBC adds the inverted operand.
	assign add_m = (op == OP_SBC) ? ~operand : operand;
	assign sum   = {1'b0, cur.acc} + {1'b0, add_m} + {{BYTE_W{1'b0}}, cur.flag_c};

	// Compare subtractor.
	always_comb begin
		case (op)
			OP_CPX:  cmp_reg = cur.xreg;
			OP_CPY:  cmp_reg = cur.yreg;
			default: cmp_reg = cur.acc;
		endcase
	end
	assign diff = {1'b0, cmp_reg} - {1'b0, operand};

	// Rotator shifts the old carry in.
	assign rot_src = (op == OP_ROL_MEM || op == OP_ROR_MEM) ? operand : cur.acc;
	assign rol_r   = {rot_src[BYTE_W-2:0], cur.flag_c};
	assign ror_r   = {cur.flag_c, rot_src[BYTE_W-1:1]};

	always_comb begin
		nxt    = cur;
		zn_val = '0;
		zn_upd = 1'b0;
		sd     = '0;
		sv     = 1'b0;
		br     = 1'b0;
		case (op)
			OP_ADC, OP_SBC: begin
				nxt.acc    = sum[BYTE_W-1:0];
				nxt.flag_c = sum[BYTE_W];
				nxt.flag_v = (cur.acc[BYTE_W-1] ^ sum[BYTE_W-1])
					& (add_m[BYTE_W-1] ^ sum[BYTE_W-1]);
				zn_val     = sum[BYTE_W-1:0];
				zn_upd     = 1'b1;
			end
			OP_AND: begin
				nxt.acc = cur.acc & operand;
				zn_val  = cur.acc & operand;
				zn_upd  = 1'b1;
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.flag_c = ~diff[BYTE_W];
				nxt.flag_z = (cmp_reg == operand);
				nxt.flag_n = diff[BYTE_W-1];
			end
			OP_INC_A: begin
				nxt.acc = cur.acc + LOW_MASK;
				zn_val  = cur.acc + LOW_MASK;
				zn_upd  = 1'b1;
			end
			OP_INC_MEM: begin
				sd     = operand + LOW_MASK;
				sv     = 1'b1;
				zn_val = operand + LOW_MASK;
				zn_upd = 1'b1;
			end
			OP_DEC_A: begin
				nxt.acc = cur.acc - LOW_MASK;
				zn_val  = cur.acc - LOW_MASK;
				zn_upd  = 1'b1;
			end
			OP_DEC_MEM: begin
				sd     = operand - LOW_MASK;
				sv     = 1'b1;
				zn_val = operand - LOW_MASK;
				zn_upd = 1'b1;
			end
			OP_INX: begin
				nxt.xreg = cur.xreg + LOW_MASK;
				zn_val   = cur.xreg + LOW_MASK;
				zn_upd   = 1'b1;
			end
			OP_INY: begin
				nxt.yreg = cur.yreg + LOW_MASK;
				zn_val   = cur.yreg + LOW_MASK;
				zn_upd   = 1'b1;
			end
			OP_DEX: begin
				nxt.xreg = cur.xreg - LOW_MASK;
				zn_val   = cur.xreg - LOW_MASK;
				zn_upd   = 1'b1;
			end
			OP_DEY: begin
				nxt.yreg = cur.yreg - LOW_MASK;
				zn_val   = cur.yreg - LOW_MASK;
				zn_upd   = 1'b1;
			end
			OP_LDA, OP_PLA: begin
				nxt.acc = operand;
				zn_val  = operand;
				zn_upd  = 1'b1;
			end
			OP_LDX, OP_PLX: begin
				nxt.xreg = operand;
				zn_val   = operand;
				zn_upd   = 1'b1;
			end
			OP_LDY, OP_PLY: begin
				nxt.yreg = operand;
				zn_val   = operand;
				zn_upd   = 1'b1;
			end
			OP_TXA: begin
				nxt.acc = cur.xreg;
				zn_val  = cur.xreg;
				zn_upd  = 1'b1;
			end
			OP_TYA: begin
				nxt.acc = cur.yreg;
				zn_val  = cur.yreg;
				zn_upd  = 1'b1;
			end
			OP_ROL_A: begin
				nxt.acc    = rol_r;
				nxt.flag_c = rot_src[BYTE_W-1];
				zn_val     = rol_r;
				zn_upd     = 1'b1;
			end
			OP_ROL_MEM: begin
				sd         = rol_r;
				sv         = 1'b1;
				nxt.flag_c = rot_src[BYTE_W-1];
				zn_val     = rol_r;
				zn_upd     = 1'b1;
			end
			OP_ROR_A: begin
				nxt.acc    = ror_r;
				nxt.flag_c = rot_src[0];
				zn_val     = ror_r;
				zn_upd     = 1'b1;
			end
			OP_ROR_MEM: begin
				sd         = ror_r;
				sv         = 1'b1;
				nxt.flag_c = rot_src[0];
				zn_val     = ror_r;
				zn_upd     = 1'b1;
			end
			OP_STA, OP_PHA: begin
				sd = cur.acc;
				sv = 1'b1;
			end
			OP_STX, OP_PHX: begin
				sd = cur.xreg;
				sv = 1'b1;
			end
			OP_STY, OP_PHY: begin
				sd = cur.yreg;
				sv = 1'b1;
			end
			OP_CLC: nxt.flag_c = 1'b0;
			OP_CLD: nxt.flag_d = 1'b0;
			OP_CLI: nxt.flag_i = 1'b0;
			OP_CLV: nxt.flag_v = 1'b0;
			OP_SEC: nxt.flag_c = 1'b1;
			OP_SED: nxt.flag_d = 1'b1;
			OP_SEI: nxt.flag_i = 1'b1;
			OP_BCC: br = ~cur.flag_c;
			OP_BCS: br = cur.flag_c;
			OP_BEQ: br = cur.flag_z;
			OP_PHP: begin
				sd = {cur.flag_n, cur.flag_v, 2'b11, cur.flag_d, cur.flag_i,
					cur.flag_z, cur.flag_c};
				sv = 1'b1;
			end
			OP_PLP: begin
				nxt.flag_n = operand[7];
				nxt.flag_v = operand[6];
				nxt.flag_d = operand[3];
				nxt.flag_i = operand[2];
				nxt.flag_z = operand[1];
				nxt.flag_c = operand[0];
			end
			default: ;
		endcase
		if (zn_upd) begin
			nxt.flag_z = (zn_val == '0);
			nxt.flag_n = |(zn_val & SIGN_MASK);
		end
	end

	assign res.store_data   = sd;
	assign res.store_valid  = sv;
	assign res.branch_taken = br;
	assign res.acc_value    = nxt.acc;
	assign res.x_value      = nxt.xreg;
	assign res.y_value      = nxt.yreg;
	assign res.status_value = {nxt.flag_n, nxt.flag_v, 2'b11, nxt.flag_d, nxt.flag_i,
		nxt.flag_z, nxt.flag_c};

endmodule

### rtl/core/ebcpu_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_regfile
// Accumulator, index registers and flags; commit the next state per item.
// ----------------------------------------------------------------------------
module ebcpu_regfile import ebcpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  arch_state_t nxt,
	output arch_state_t cur
);

	arch_state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (commit) begin
			state_q <= nxt;
		end
	end

	assign cur = state_q;

endmodule

### tb/eight_bit_cpu_alu_register_execute_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_register_execute_core_tb
// Self-checking bench for the 8-bit execute core. A directed pass walks every
// operation with boundary operands. Random instruction streams follow, run
// under four traffic patterns: no idling, sender gaps, receiver stalls, both.
// Each result item is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_register_execute_core_tb;
	import ebcpu_pkg::*;

	// Codes past the last defined operation behave as NOP.
	localparam logic [FUNC_W-1:0] FIRST_UNUSED_FUNC = 6'd45;
	localparam logic [FUNC_W-1:0] LAST_UNUSED_FUNC  = 6'd63;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct {
		logic [FUNC_W-1:0] op;
		logic [BYTE_W-1:0] operand;
	} cmd_item_t;

	logic clk;
	logic arst_n;

	ebcpu_in_if  cmd_if ();
	ebcpu_out_if res_if ();

	eight_bit_cpu_alu_register_execute_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	// Instructions waiting to be driven, and results predicted but not yet seen.
	cmd_item_t cmd_backlog[$];
	result_t   predicted_results[$];

	// Predictor copy of the registers and flags.
	arch_state_t cpu;

	int send_idle_pct;
	int recv_stall_pct;
	logic cmd_taken;

	int error_count;
	int items_sent;
	int results_checked;
	int stores_seen;
	int branches_taken;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	task automatic set_zn(input logic [BYTE_W-1:0] v);
		cpu.flag_z = (v == '0);
		cpu.flag_n = v[BYTE_W-1];
	endtask

	// Compare sets C on reg >= m, Z on equality, N from the difference.
	task automatic compare_reg(input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] m);
		logic [BYTE_W-1:0] diff;
		diff = r - m;
		cpu.flag_c = (r >= m);
		cpu.flag_z = (r == m);
		cpu.flag_n = diff[BYTE_W-1];
	endtask

	// Rotate through carry: the old carry enters, the bit shifted out leaves.
	task automatic rotate_carry(input logic left, input logic [BYTE_W-1:0] v,
			output logic [BYTE_W-1:0] r);
		if (left) begin
			r = {v[BYTE_W-2:0], cpu.flag_c};
			cpu.flag_c = v[BYTE_W-1];
		end else begin
			r = {cpu.flag_c, v[BYTE_W-1:1]};
			cpu.flag_c = v[0];
		end
		set_zn(r);
	endtask

	function automatic logic [BYTE_W-1:0] packed_status();
		return {cpu.flag_n, cpu.flag_v, 2'b11, cpu.flag_d, cpu.flag_i, cpu.flag_z, cpu.flag_c};
	endfunction

	// Advance the predictor by one instruction and form the result it yields.
	task automatic execute_instruction(input logic [FUNC_W-1:0] op,
			input logic [BYTE_W-1:0] m, output result_t r);
		logic [BYTE_W:0]   sum;
		logic [BYTE_W-1:0] addend;
		logic [BYTE_W-1:0] sd;
		logic              sv;
		logic              br;
		sd = '0;
		sv = 1'b0;
		br = 1'b0;
		case (op)
			OP_ADC, OP_SBC: begin
				// SBC is ADC with the operand inverted; binary only, D ignored.
				addend = (op == OP_SBC) ? ~m : m;
				sum = {1'b0, cpu.acc} + {1'b0, addend} + {{BYTE_W{1'b0}}, cpu.flag_c};
				cpu.flag_c = sum[BYTE_W];
				cpu.flag_v = (((cpu.acc ^ sum[BYTE_W-1:0]) & (addend ^ sum[BYTE_W-1:0]))
					& SIGN_MASK) != '0;
				cpu.acc = sum[BYTE_W-1:0];
				set_zn(cpu.acc);
			end
			OP_AND: begin
				cpu.acc = cpu.acc & m;
				set_zn(cpu.acc);
			end
			OP_CMP: compare_reg(cpu.acc, m);
			OP_CPX: compare_reg(cpu.xreg, m);
			OP_CPY: compare_reg(cpu.yreg, m);
			OP_INC_A: begin
				cpu.acc = cpu.acc + LOW_MASK;
				set_zn(cpu.acc);
			end
			OP_INC_MEM: begin
				sd = m + LOW_MASK;
				sv = 1'b1;
				set_zn(sd);
			end
			OP_DEC_A: begin
				cpu.acc = cpu.acc - LOW_MASK;
				set_zn(cpu.acc);
			end
			OP_DEC_MEM: begin
				sd = m - LOW_MASK;
				sv = 1'b1;
				set_zn(sd);
			end
			OP_INX: begin
				cpu.xreg = cpu.xreg + LOW_MASK;
				set_zn(cpu.xreg);
			end
			OP_INY: begin
				cpu.yreg = cpu.yreg + LOW_MASK;
				set_zn(cpu.yreg);
			end
			OP_DEX: begin
				cpu.xreg = cpu.xreg - LOW_MASK;
				set_zn(cpu.xreg);
			end
			OP_DEY: begin
				cpu.yreg = cpu.yreg - LOW_MASK;
				set_zn(cpu.yreg);
			end
			OP_LDA, OP_PLA: begin
				cpu.acc = m;
				set_zn(cpu.acc);
			end
			OP_LDX, OP_PLX: begin
				cpu.xreg = m;
				set_zn(cpu.xreg);
			end
			OP_LDY, OP_PLY: begin
				cpu.yreg = m;
				set_zn(cpu.yreg);
			end
			OP_TXA: begin
				cpu.acc = cpu.xreg;
				set_zn(cpu.acc);
			end
			OP_TYA: begin
				cpu.acc = cpu.yreg;
				set_zn(cpu.acc);
			end
			OP_ROL_A: rotate_carry(1'b1, cpu.acc, cpu.acc);
			OP_ROR_A: rotate_carry(1'b0, cpu.acc, cpu.acc);
			OP_ROL_MEM: begin
				rotate_carry(1'b1, m, sd);
				sv = 1'b1;
			end
			OP_ROR_MEM: begin
				rotate_carry(1'b0, m, sd);
				sv = 1'b1;
			end
			OP_STA, OP_PHA: begin
				sd = cpu.acc;
				sv = 1'b1;
			end
			OP_STX, OP_PHX: begin
				sd = cpu.xreg;
				sv = 1'b1;
			end
			OP_STY, OP_PHY: begin
				sd = cpu.yreg;
				sv = 1'b1;
			end
			OP_CLC: cpu.flag_c = 1'b0;
			OP_CLD: cpu.flag_d = 1'b0;
			OP_CLI: cpu.flag_i = 1'b0;
			OP_CLV: cpu.flag_v = 1'b0;
			OP_SEC: cpu.flag_c = 1'b1;
			OP_SED: cpu.flag_d = 1'b1;
			OP_SEI: cpu.flag_i = 1'b1;
			// Branch decisions use the flags as they stand before the step.
			OP_BCC: br = !cpu.flag_c;
			OP_BCS: br = cpu.flag_c;
			OP_BEQ: br = cpu.flag_z;
			OP_PHP: begin
				sd = packed_status();
				sv = 1'b1;
			end
			OP_PLP: begin
				// Bits 5 and 4 of the pulled byte carry no flag.
				cpu.flag_n = m[7];
				cpu.flag_v = m[6];
				cpu.flag_d = m[3];
				cpu.flag_i = m[2];
				cpu.flag_z = m[1];
				cpu.flag_c = m[0];
			end
			default: ;
		endcase
		r.store_data   = sd;
		r.store_valid  = sv;
		r.branch_taken = br;
		r.acc_value    = cpu.acc;
		r.x_value      = cpu.xreg;
		r.y_value      = cpu.yreg;
		r.status_value = packed_status();
	endtask

	// ------------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
			input logic [BYTE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got 0x%02h expected 0x%02h",
				results_checked, name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic queue_cmd(input logic [FUNC_W-1:0] op, input logic [BYTE_W-1:0] m);
		cmd_item_t it;
		it.op = op;
		it.operand = m;
		cmd_backlog.push_back(it);
	endtask

	// Bias toward boundary bytes so equal compares, carries and overflows occur.
	function automatic logic [BYTE_W-1:0] pick_operand();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			4: return 8'h01;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// Fill the backlog with a random program and let it drain completely.
	task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
		int queued;
		logic [FUNC_W-1:0] setup_op;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queued = 0;
		while (queued < count) begin
			case ($urandom_range(9))
				0, 1: begin
					// Flag-setting step followed by a branch that tests it.
					case ($urandom_range(4))
						0: setup_op = OP_CMP;
						1: setup_op = OP_CPX;
						2: setup_op = OP_CPY;
						3: setup_op = OP_ADC;
						default: setup_op = OP_SBC;
					endcase
					queue_cmd(setup_op, pick_operand());
					queue_cmd(FUNC_W'(OP_BCC + $urandom_range(2)), pick_operand());
					queued += 2;
				end
				2: begin
					queue_cmd(FUNC_W'($urandom_range(LAST_UNUSED_FUNC, FIRST_UNUSED_FUNC)),
						BYTE_W'($urandom_range(255)));
					queued++;
				end
				default: begin
					queue_cmd(FUNC_W'($urandom_range(OP_PLY, OP_ADC)), pick_operand());
					queued++;
				end
			endcase
		end
		wait_idle();
	endtask

	// Hold until every queued item has been taken and every result has come back.
	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || cmd_if.valid || predicted_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and run control
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run; the slowest correct run needs well under a tenth of this.
	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cpu = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		items_sent = 0;
		results_checked = 0;
		stores_seen = 0;
		branches_taken = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass: every operation at least once, boundary operands, flag corners.
		queue_cmd(OP_LDA, 8'h00);       // load zero sets Z
		queue_cmd(OP_LDX, 8'hFF);       // load negative sets N
		queue_cmd(OP_LDY, 8'h80);
		queue_cmd(OP_CPX, 8'hFF);       // equal compare: C and Z
		queue_cmd(OP_BEQ, 8'h00);
		queue_cmd(OP_CPY, 8'h7F);
		queue_cmd(OP_BCS, 8'h00);
		queue_cmd(OP_ADC, 8'hFF);       // 0 + FF + carry wraps to zero with carry out
		queue_cmd(OP_BCC, 8'h00);
		queue_cmd(OP_LDA, 8'h7F);
		queue_cmd(OP_CLC, 8'h00);
		queue_cmd(OP_ADC, 8'h01);       // positive overflow into the sign bit
		queue_cmd(OP_SBC, 8'h00);       // borrow in, negative overflow back to 7F
		queue_cmd(OP_CMP, 8'h80);       // less-than compare clears C
		queue_cmd(OP_AND, 8'h80);
		queue_cmd(OP_INC_A, 8'h00);
		queue_cmd(OP_DEC_A, 8'h00);
		queue_cmd(OP_INC_MEM, 8'hFF);   // memory wrap to zero
		queue_cmd(OP_DEC_MEM, 8'h00);   // memory wrap to FF
		queue_cmd(OP_INX, 8'h00);
		queue_cmd(OP_INY, 8'h00);
		queue_cmd(OP_DEX, 8'h00);
		queue_cmd(OP_DEY, 8'h00);
		queue_cmd(OP_TXA, 8'h00);
		queue_cmd(OP_TYA, 8'h00);
		queue_cmd(OP_SEC, 8'h00);
		queue_cmd(OP_ROL_A, 8'h00);     // old carry shifts into bit 0
		queue_cmd(OP_ROR_A, 8'h00);
		queue_cmd(OP_ROL_MEM, 8'h80);
		queue_cmd(OP_ROR_MEM, 8'h01);
		queue_cmd(OP_STA, 8'h55);
		queue_cmd(OP_STX, 8'hAA);
		queue_cmd(OP_STY, 8'h00);
		queue_cmd(OP_SED, 8'h00);       // decimal flag kept but never applied
		queue_cmd(OP_ADC, 8'h09);
		queue_cmd(OP_SEI, 8'h00);
		queue_cmd(OP_PHP, 8'h00);       // pushed status carries bits 5 and 4 set
		queue_cmd(OP_CLD, 8'h00);
		queue_cmd(OP_CLI, 8'h00);
		queue_cmd(OP_CLV, 8'h00);
		queue_cmd(OP_PLP, 8'hFF);       // pulled bits 5 and 4 are dropped
		queue_cmd(OP_PHP, 8'h00);
		queue_cmd(OP_PLP, 8'h00);
		queue_cmd(OP_NOP, 8'hFF);
		queue_cmd(OP_PHA, 8'h00);
		queue_cmd(OP_PHX, 8'h00);
		queue_cmd(OP_PHY, 8'h00);
		queue_cmd(OP_PLA, 8'h80);
		queue_cmd(OP_PLX, 8'h00);
		queue_cmd(OP_PLY, 8'hFF);
		queue_cmd(FIRST_UNUSED_FUNC, 8'hFF);  // undefined codes act as NOP
		queue_cmd(LAST_UNUSED_FUNC, 8'h00);
		wait_idle();

		run_random_phase(ITEMS_PER_PHASE, 0, 0);
		run_random_phase(ITEMS_PER_PHASE, 62, 0);
		run_random_phase(ITEMS_PER_PHASE, 0, 62);
		run_random_phase(ITEMS_PER_PHASE, 27, 27);

		// Let any stray result surface before closing out.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (predicted_results.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived",
				predicted_results.size()));

		$display("Ran %0d instructions through all operations and four traffic patterns.",
			items_sent);
		$display("Checked %0d results: %0d with a store byte, %0d with a branch taken.",
			results_checked, stores_seen, branches_taken);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: present the next item once the current one is taken
	// ------------------------------------------------------------------------

	always @(negedge clk) begin : drive_cmd
		cmd_item_t next_cmd;
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			cmd_if.func <= '0;
			cmd_if.operand <= '0;
		end else if (!cmd_if.valid || cmd_taken) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = cmd_backlog.pop_front();
				cmd_if.valid <= 1'b1;
				cmd_if.func <= next_cmd.op;
				cmd_if.operand <= next_cmd.operand;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure: drop ready at random for the stall share.
	always @(negedge clk) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Monitor: check results against the oldest prediction, then predict
	// ------------------------------------------------------------------------

	always @(posedge clk) begin : watch_channels
		result_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			// Check before predicting; a result never belongs to an item taken this edge.
			if (res_if.valid && res_if.ready) begin
				results_checked++;
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none predicted",
						results_checked));
				end else begin
					want = predicted_results.pop_front();
					check_field("store_data", res_if.store_data, want.store_data);
					check_field("store_valid", BYTE_W'(res_if.store_valid),
						BYTE_W'(want.store_valid));
					check_field("branch_taken", BYTE_W'(res_if.branch_taken),
						BYTE_W'(want.branch_taken));
					check_field("acc_value", res_if.acc_value, want.acc_value);
					check_field("x_value", res_if.x_value, want.x_value);
					check_field("y_value", res_if.y_value, want.y_value);
					check_field("status_value", res_if.status_value, want.status_value);
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				execute_instruction(cmd_if.func, cmd_if.operand, want);
				predicted_results.push_back(want);
				items_sent++;
				if (want.store_valid)
					stores_seen++;
				if (want.branch_taken)
					branches_taken++;
			end
			cmd_taken <= cmd_if.valid && cmd_if.ready;
		end
	end

endmodule

### filelist.f
rtl/core/ebcpu_pkg.sv
rtl/core/ebcpu_in_if.sv
rtl/core/ebcpu_out_if.sv
rtl/core/ebcpu_alu.sv
rtl/core/ebcpu_regfile.sv
rtl/core/eight_bit_cpu_alu_register_execute_core.sv
tb/eight_bit_cpu_alu_register_execute_core_tb.sv
